// ===== sv/rcsfd_pkg.sv =====
`timescale 1ns / 1ps

package rcsfd_pkg;

	// buffer geometry
	localparam int BUF_BYTES    = 32;
	localparam int NUM_CHANNELS = 8;
	localparam int IDX_W        = $clog2(BUF_BYTES + 1);
	localparam int ADDR_W       = $clog2(BUF_BYTES);
	localparam int NUM_WORDS    = BUF_BYTES / 2;
	localparam int WORD_AW      = $clog2(NUM_WORDS);
	localparam int CH_AW        = $clog2(NUM_CHANNELS);
	localparam int CHAN_W       = 12;

	// decode walk over words 1..15, word 8 skipped
	localparam int WALK_W = 4;
	localparam logic [WALK_W-1:0] FIRST_WORD = 4'd1;
	localparam logic [WALK_W-1:0] SKIP_WORD  = 4'd8;
	localparam logic [WALK_W-1:0] LAST_WORD  = 4'd15;

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// configuration
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_TMO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BYTES  = 2'd2;
	localparam logic [15:0] FRAME_GAP_RST = 16'd5000;
	localparam logic [19:0] LINK_TMO_RST  = 20'd50000;
	localparam logic [5:0]  MIN_BYTES_RST = 6'd31;

	// item modes
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_POLL = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  data_byte;
		logic [31:0] now_us;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_0;
		logic [CHAN_W-1:0] chan_1;
		logic [CHAN_W-1:0] chan_2;
		logic [CHAN_W-1:0] chan_3;
		logic [CHAN_W-1:0] chan_4;
		logic [CHAN_W-1:0] chan_5;
		logic [CHAN_W-1:0] chan_6;
		logic [CHAN_W-1:0] chan_7;
		logic [7:0]        link_count;
		logic              frame_decoded;
	} result_t;

	// what the front hands to the back for one item
	typedef struct packed {
		logic              store;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              decode;
		logic [7:0]        link_count;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic [CH_AW-1:0]  chan;
		logic [CHAN_W-1:0] value;
	} word_map_t;

	// word range to channel and offset, both bounds exclusive
	function automatic word_map_t map_word(logic [15:0] w);
		word_map_t m;
		m.hit   = 1'b0;
		m.chan  = '0;
		m.value = '0;
		if (w > 16'd0 && w < 16'd1024) begin
			m.hit = 1'b1; m.chan = 3'd2; m.value = CHAN_W'(w + 16'd988);
		end
		if (w > 16'd1024 && w < 16'd2048) begin
			m.hit = 1'b1; m.chan = 3'd0; m.value = CHAN_W'(w - 16'd12);
		end
		if (w > 16'd2048 && w < 16'd3072) begin
			m.hit = 1'b1; m.chan = 3'd1; m.value = CHAN_W'(w - 16'd1036);
		end
		if (w > 16'd3072 && w < 16'd4096) begin
			m.hit = 1'b1; m.chan = 3'd3; m.value = CHAN_W'(w - 16'd2060);
		end
		if (w > 16'd4096 && w < 16'd5120) begin
			m.hit = 1'b1; m.chan = 3'd4; m.value = CHAN_W'(w - 16'd3084);
		end
		if (w > 16'd5120 && w < 16'd6144) begin
			m.hit = 1'b1; m.chan = 3'd5; m.value = CHAN_W'(w - 16'd4108);
		end
		if (w > 16'd7168 && w < 16'd8192) begin
			m.hit = 1'b1; m.chan = 3'd6; m.value = CHAN_W'(w - 16'd6156);
		end
		if (w > 16'd8192 && w < 16'd9216) begin
			m.hit = 1'b1; m.chan = 3'd7; m.value = CHAN_W'(w - 16'd7180);
		end
		return m;
	endfunction

endpackage

// ===== sv/rcsfd_front.sv =====
`timescale 1ns / 1ps

module rcsfd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rcsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcsfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  rcsfd_pkg::item_t                   item,
	input  logic                               q_full,
	output logic                               q_push,
	output rcsfd_pkg::cmd_t                    q_cmd
);
	import rcsfd_pkg::*;

	logic [15:0]      gap_q;
	logic [19:0]      tmo_q;
	logic [5:0]       min_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      last_q;
	logic [7:0]       count_q;

	logic [31:0]      gap;
	logic             gap_hit;
	logic             tmo_hit;
	logic             has_room;
	logic             do_decode;
	logic [7:0]       count_nxt;
	logic             accept;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign q_push     = accept;

	always_comb begin
		gap       = item.now_us - last_q;
		gap_hit   = gap > {16'd0, gap_q};
		tmo_hit   = gap > {12'd0, tmo_q};
		has_room  = idx_q < IDX_W'(BUF_BYTES);
		do_decode = (item.mode == MODE_BYTE) && gap_hit && (idx_q >= IDX_W'(min_q));
		if (item.mode == MODE_BYTE) begin
			count_nxt = do_decode ? 8'd1 : count_q + 8'd1;
		end else begin
			count_nxt = tmo_hit ? 8'd0 : count_q;
		end
		q_cmd.store      = (item.mode == MODE_BYTE) && has_room;
		q_cmd.addr       = idx_q[ADDR_W-1:0];
		q_cmd.data       = item.data_byte;
		q_cmd.decode     = do_decode;
		q_cmd.link_count = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= FRAME_GAP_RST;
			tmo_q <= LINK_TMO_RST;
			min_q <= MIN_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_GAP: gap_q <= cfg_data[15:0];
				CFG_LINK_TMO:  tmo_q <= cfg_data[19:0];
				CFG_MIN_BYTES: min_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			last_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
			if (item.mode == MODE_BYTE) begin
				last_q <= item.now_us;
				if (do_decode) begin
					idx_q <= IDX_W'(1);
				end else if (has_room) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(BUF_BYTES))
		else $error("byte index past buffer end");

	a_decode_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_decode |=> idx_q == IDX_W'(1) && count_q == 8'd1)
		else $error("decode did not restart byte and link counts");

endmodule

// ===== sv/rcsfd_queue.sv =====
`timescale 1ns / 1ps

module rcsfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcsfd_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output rcsfd_pkg::cmd_t head
);
	import rcsfd_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign full      = cnt_q == Q_CW'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into full queue");

endmodule

// ===== sv/rcsfd_back.sv =====
`timescale 1ns / 1ps

module rcsfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  rcsfd_pkg::cmd_t    q_head,
	output logic               q_pop,
	output logic               result_valid,
	input  logic               result_stall,
	output rcsfd_pkg::result_t result
);
	import rcsfd_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_WALK = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

	back_state_t       state_q;
	logic [15:0]       words_q [NUM_WORDS];
	logic [CHAN_W-1:0] chan_q  [NUM_CHANNELS];
	logic [WALK_W-1:0] walk_q;
	logic [7:0]        lc_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              out_free;
	logic              load;
	logic              load_decoded;
	logic [7:0]        load_count;
	logic [15:0]       word_rd;
	word_map_t         wmap;

	assign out_free     = !res_valid_q || !result_stall;
	assign q_pop        = (state_q == B_IDLE) && q_not_empty && (q_head.decode || out_free);
	assign load         = ((state_q == B_IDLE) && q_pop && !q_head.decode)
	                   || ((state_q == B_DONE) && out_free);
	assign load_decoded = state_q == B_DONE;
	assign load_count   = (state_q == B_DONE) ? lc_q : q_head.link_count;
	assign word_rd      = words_q[WORD_AW'(walk_q)];
	assign wmap         = map_word(word_rd);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			walk_q  <= FIRST_WORD;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_pop && q_head.decode) begin
						state_q <= B_WALK;
						walk_q  <= FIRST_WORD;
					end
				end
				B_WALK: begin
					if (walk_q == LAST_WORD) begin
						state_q <= B_DONE;
					end else begin
						walk_q <= walk_q + WALK_W'(1);
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// byte 2i is the high half of word i
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (q_pop && q_head.store) begin
			if (q_head.addr[0]) begin
				words_q[q_head.addr[ADDR_W-1:1]][7:0] <= q_head.data;
			end else begin
				words_q[q_head.addr[ADDR_W-1:1]][15:8] <= q_head.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chan_q[i] <= '0;
			end
		end else if (state_q == B_WALK && walk_q != SKIP_WORD && wmap.hit) begin
			chan_q[wmap.chan] <= wmap.value;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.decode) begin
			lc_q <= q_head.link_count;
		end
		if (load) begin
			res_q.chan_0        <= chan_q[0];
			res_q.chan_1        <= chan_q[1];
			res_q.chan_2        <= chan_q[2];
			res_q.chan_3        <= chan_q[3];
			res_q.chan_4        <= chan_q[4];
			res_q.chan_5        <= chan_q[5];
			res_q.chan_6        <= chan_q[6];
			res_q.chan_7        <= chan_q[7];
			res_q.link_count    <= load_count;
			res_q.frame_decoded <= load_decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DONE |-> walk_q == LAST_WORD)
		else $error("decode finished before last word");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_WALK |=> !(state_q == B_IDLE && $past(q_pop)))
		else $error("command taken during decode walk");

endmodule

// ===== sv/rc_satellite_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// channel | handshake                     | payload
// item    | item_valid / item_stall       | item (mode, data_byte, now_us)
// result  | result_valid / result_stall   | result (chan_0..chan_7, link_count, frame_decoded)
// cfg     | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// a poll or a non-decoding byte is popped by the back end and loaded straight into the output register
// a decoding byte goes through pop, 15 word steps through the buffer read port, then hand-off
// the front takes an item each cycle while the 2-entry command queue has room
// reset clears buffer, channels, counters and config to defaults at once, no sweep
// a stalled result holds back the next non-decode pop; a decode walk still starts and
// waits in its done state until the output register is free

module rc_satellite_frame_decoder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rcsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcsfd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  rcsfd_pkg::item_t                 item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output rcsfd_pkg::result_t               result
);
	import rcsfd_pkg::*;

	// front to queue
	logic q_full;
	logic q_push;
	cmd_t q_cmd;

	// queue to back
	logic q_pop;
	logic q_not_empty;
	cmd_t q_head;

	// front: config registers, timing compare, byte index and link count
	rcsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	// short command queue so the front keeps taking bytes during a decode until the queue fills
	rcsfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: frame buffer, decode walk, channel values, output register
	rcsfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// a decode always restarts the link count, so a decode result reports one byte
	a_decode_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_decoded |-> result.link_count == 8'd1)
		else $error("decode result with wrong link count");

endmodule
